// ===== src/egcd_pkg.sv =====
// Package for the extended Euclidean gcd core: widths, types, controller state and command/status buses.
package egcd_pkg;

   localparam int WIDTH    = 32;
   localparam int CNT_W    = $clog2(WIDTH);

   typedef logic [WIDTH-1:0]        opnd_type;
   typedef logic signed [WIDTH:0]   coef_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   localparam cnt_type CNT_LAST = cnt_type'(WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } egcd_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
   } egcd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic r1_zero;
      logic div_last;
   } egcd_status_type;

endpackage

// ===== src/egcd_datapath.sv =====
// Datapath of the extended gcd core: remainder/coefficient registers and shift-subtract divider.
module egcd_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  egcd_pkg::egcd_cmd_type    cmd,
   input  egcd_pkg::opnd_type        operand_a,
   input  egcd_pkg::opnd_type        operand_b,
   output egcd_pkg::egcd_status_type status,
   output egcd_pkg::opnd_type        divisor,
   output egcd_pkg::coef_type        coef_x,
   output egcd_pkg::coef_type        coef_y
);
   import egcd_pkg::*;

   opnd_type r0_ff, r0_in, r1_ff, r1_in;
   coef_type s0_ff, s0_in, s1_ff, s1_in;
   coef_type t0_ff, t0_in, t1_ff, t1_in;
   opnd_type rem_ff, rem_in, dvd_ff, dvd_in;
   coef_type ps_ff, ps_in, pt_ff, pt_in;
   cnt_type  cnt_ff, cnt_in;

   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   rem_diff;
   logic             qbit;

   // one restoring division step; q*s1 and q*t1 build up MSB first
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[WIDTH-1]};
      rem_diff = rem_sh - {1'b0, r1_ff};
      qbit     = (rem_sh >= {1'b0, r1_ff});
   end

   always_comb begin
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      t0_in  = t0_ff;
      t1_in  = t1_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      ps_in  = ps_ff;
      pt_in  = pt_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         r0_in = operand_a;
         r1_in = operand_b;
         s0_in = coef_type'(1);
         s1_in = '0;
         t0_in = '0;
         t1_in = coef_type'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         dvd_in = r0_ff;
         ps_in  = '0;
         pt_in  = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = qbit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         ps_in  = (ps_ff <<< 1) + (qbit ? s1_ff : coef_type'(0));
         pt_in  = (pt_ff <<< 1) + (qbit ? t1_ff : coef_type'(0));
         cnt_in = cnt_ff + cnt_type'(1);
      end
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - ps_ff;
         t0_in = t1_ff;
         t1_in = t0_ff - pt_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      ps_ff  <= ps_in;
      pt_ff  <= pt_in;
      cnt_ff <= cnt_in;
   end

   assign status.r1_zero  = (r1_ff == '0);
   assign status.div_last = (cnt_ff == CNT_LAST);

   assign divisor = r0_ff;
   assign coef_x  = s0_ff;
   assign coef_y  = t0_ff;

   // partial remainder stays below the divisor through the whole division
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < r1_ff))
      else $error("partial remainder not below divisor");

   // a step is only ever taken with a nonzero divisor
   a_update_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.update || cmd.div_init) |-> (r1_ff != '0))
      else $error("division with zero divisor");

   // the remainder loaded by a step is smaller than the old divisor
   a_r1_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (r1_ff < r0_ff))
      else $error("remainder sequence not decreasing");

endmodule

// ===== src/egcd_controller.sv =====
// Controller state machine of the extended gcd core.
module egcd_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  egcd_pkg::egcd_status_type status,
   output egcd_pkg::egcd_cmd_type    cmd,
   output logic                      busy,
   output logic                      rsp_strobe
);
   import egcd_pkg::*;

   egcd_state_type state_ff, state_in;

   // update happens the cycle after the last division step
   logic update_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            // an update cycle still sees the old r1; check again after it
            if (update_ff) begin
               state_in = ST_CHECK;
            end else begin
               state_in = status.r1_zero ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV:   if (status.div_last) state_in = ST_CHECK;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CHECK: begin
            cmd.update   = update_ff;
            cmd.div_init = !update_ff && !status.r1_zero;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.update   = 1'b0;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         update_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         update_ff <= (state_ff == ST_DIV) && status.div_last;
      end
   end

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_CHECK))
      else $error("accepted transfer did not start work");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_div_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_CHECK && update_ff))
      else $error("division end not followed by update");

   a_no_strobe_busy_low: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("strobe while idle");

   a_update_not_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (state_ff == ST_CHECK))
      else $error("update outside check state");

endmodule

// ===== src/extended_euclidean_gcd_core.sv =====
// Top level of the extended Euclidean gcd core: controller plus datapath.
//
// Computes divisor = gcd(a, b) and Bezout coefficients coef_x, coef_y with
// divisor = a*coef_x + b*coef_y, the same triple as the recursive textbook
// form (b = 0 gives (a, 1, 0); a = b = 0 gives (0, 1, 0)). A transfer is
// taken when start is high and busy is low; busy then stays high until the
// result has been shown. The result appears for exactly one cycle with
// rsp_strobe high and must be captured then: the receiver cannot stall it.
// One item at a time. Each item runs K Euclid steps (at most about 46 for
// 32-bit operands); each step is a check-state pass that starts the
// divider, a one-bit-per-cycle restoring divider that yields WIDTH quotient
// bits and builds q*s1 and q*t1 in the same cycles, and a second check-state
// pass that applies the remainder/coefficient update. A final check that
// finds the remainder zero and the strobe cycle close the item; busy drops
// the cycle after the strobe.
module extended_euclidean_gcd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  egcd_pkg::opnd_type  req_operand_a,
   input  egcd_pkg::opnd_type  req_operand_b,
   output logic                rsp_strobe,
   output egcd_pkg::opnd_type  rsp_divisor,
   output egcd_pkg::coef_type  rsp_coef_x,
   output egcd_pkg::coef_type  rsp_coef_y
);
   import egcd_pkg::*;

   egcd_cmd_type    ctl_cmd;
   egcd_status_type dp_status;

   // controller: start handshake, step sequencing, update, result strobe
   egcd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (dp_status),
      .cmd        (ctl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   egcd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .status    (dp_status),
      .divisor   (rsp_divisor),
      .coef_x    (rsp_coef_x),
      .coef_y    (rsp_coef_y)
   );

endmodule
